// ===== rtl/disk_request_scheduler_top_assert.svh =====
// Assertion macros used by the checker in dsch_checker.sv.
`ifndef DISK_REQUEST_SCHEDULER_TOP_ASSERT_SVH
`define DISK_REQUEST_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication.
`define DSCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dsch_pkg.sv =====
package dsch_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TRACK_BITS  = 8;
  localparam int TIME_BITS   = 32;

  localparam int IDX_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADV_BITS      = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;
  localparam int STATUS_BITS   = 3;

  localparam int IN_RAW_BITS   = TRACK_BITS + TIME_BITS;
  localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_PEND_LSB  = 2 * TRACK_BITS + 2 * TIME_BITS + 1;
  localparam int OUT_RAW_BITS  = OUT_PEND_LSB + CNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_ADDED  = 3'd0,
    ST_FULL   = 3'd1,
    ST_SERVED = 3'd2,
    ST_IDLE   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCAN_MODE   = 2'd0,
    CFG_START_TRACK = 2'd1,
    CFG_IDLE_ADV    = 2'd2,
    CFG_REV_ADV     = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_COMMIT,
    FSM_OUT
  } fsm_e;

  // best-so-far candidate walking down the cell chain
  typedef struct packed {
    logic                  found;
    logic [IDX_BITS-1:0]   idx;
    logic [TRACK_BITS-1:0] gap;
    logic [TRACK_BITS-1:0] trk;
  } cand_t;

  // scheduler state seen by every cell
  typedef struct packed {
    logic [TRACK_BITS-1:0] head;
    logic [TIME_BITS-1:0]  now;
    logic                  scan;
    logic                  up;
  } view_t;

  // write control for the cell row
  typedef struct packed {
    logic                  load;
    logic                  remove;
    logic [IDX_BITS-1:0]   sel;
    logic [TRACK_BITS-1:0] trk;
    logic [TIME_BITS-1:0]  arr;
  } cell_ctl_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]   pending;
    logic                  up;
    logic [TIME_BITS-1:0]  total;
    logic [TIME_BITS-1:0]  now;
    logic [TRACK_BITS-1:0] seek;
    logic [TRACK_BITS-1:0] served;
    status_e               status;
  } res_t;

  function automatic logic [TRACK_BITS-1:0] abs_diff(input logic [TRACK_BITS-1:0] a,
                                                     input logic [TRACK_BITS-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/dsch_cell.sv =====
module dsch_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [dsch_pkg::IDX_BITS-1:0]  my_idx_i,
  input  dsch_pkg::cell_ctl_t            ctl_i,
  input  dsch_pkg::view_t                view_i,
  input  logic [dsch_pkg::TRACK_BITS-1:0] nb_trk_i,
  input  logic [dsch_pkg::TIME_BITS-1:0]  nb_arr_i,
  input  logic                           nb_valid_i,
  input  dsch_pkg::cand_t                cand_i,
  output dsch_pkg::cand_t                cand_o,
  output logic [dsch_pkg::TRACK_BITS-1:0] trk_o,
  output logic [dsch_pkg::TIME_BITS-1:0]  arr_o,
  output logic                           valid_o
);
  import dsch_pkg::*;

  logic [TRACK_BITS-1:0] trk_q;
  logic [TIME_BITS-1:0]  arr_q;
  logic                  valid_q;
  logic                  elig_q, elig_d;
  logic [TRACK_BITS-1:0] dist_q, dist_d;
  cand_t                 cand_q, cand_d;
  logic                  shift, load, dir_ok, take_own;

  assign shift = ctl_i.remove && (my_idx_i >= ctl_i.sel);
  assign load  = ctl_i.load && (my_idx_i == ctl_i.sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift) begin
      valid_q <= nb_valid_i;
    end else if (load) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      trk_q <= nb_trk_i;
      arr_q <= nb_arr_i;
    end else if (load) begin
      trk_q <= ctl_i.trk;
      arr_q <= ctl_i.arr;
    end
  end

  always_comb begin
    dir_ok = view_i.up ? (trk_q >= view_i.head) : (trk_q < view_i.head);
    elig_d = valid_q && (arr_q <= view_i.now) && (!view_i.scan || dir_ok);
    dist_d = abs_diff(view_i.head, trk_q);
  end

  assign take_own = elig_q && (!cand_i.found || (dist_q < cand_i.gap));

  always_comb begin
    cand_d = cand_i;
    if (take_own) begin
      cand_d.found = 1'b1;
      cand_d.idx   = my_idx_i;
      cand_d.gap   = dist_q;
      cand_d.trk   = trk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elig_q <= 1'b0;
      cand_q <= '0;
    end else begin
      elig_q <= elig_d;
      cand_q <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign cand_o  = cand_q;
  assign trk_o   = trk_q;
  assign arr_o   = arr_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/dsch_chain.sv =====
module dsch_chain (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dsch_pkg::cell_ctl_t             ctl_i,
  input  dsch_pkg::view_t                 view_i,
  output logic [dsch_pkg::TRACK_BITS-1:0] head0_trk_o,
  output dsch_pkg::cand_t                 best_o
);
  import dsch_pkg::*;

  logic [TRACK_BITS-1:0] trk   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]  arr   [QUEUE_DEPTH];
  logic                  valid [QUEUE_DEPTH];
  cand_t                 cand  [QUEUE_DEPTH+1];

  assign cand[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TRACK_BITS-1:0] nb_trk;
    logic [TIME_BITS-1:0]  nb_arr;
    logic                  nb_valid;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb_trk   = '0;
      assign nb_arr   = '0;
      assign nb_valid = 1'b0;
    end else begin : g_mid
      assign nb_trk   = trk[i+1];
      assign nb_arr   = arr[i+1];
      assign nb_valid = valid[i+1];
    end

    dsch_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .my_idx_i   (IDX_BITS'(i)),
      .ctl_i      (ctl_i),
      .view_i     (view_i),
      .nb_trk_i   (nb_trk),
      .nb_arr_i   (nb_arr),
      .nb_valid_i (nb_valid),
      .cand_i     (cand[i]),
      .cand_o     (cand[i+1]),
      .trk_o      (trk[i]),
      .arr_o      (arr[i]),
      .valid_o    (valid[i])
    );
  end

  assign head0_trk_o = trk[0];
  assign best_o      = cand[QUEUE_DEPTH];

endmodule

// ===== rtl/disk_request_scheduler_top.sv =====
// channel   | direction | tdata / data                         | tuser
// s_axis    | in        | track[7:0] arrival_time[39:8]        | func
// m_axis    | out       | served_track[7:0] seek_distance[15:8] | status
//           |           | time_now[47:16] total_seek[79:48]    |
//           |           | sweeping_up[80] pending_count[85:81] |
// cfg       | in        | cfg_index_i, cfg_data_i              | -
//
// Add, full, empty and the first service in shortest-seek mode (oldest entry, no search)
// go straight from accept to commit and output. Other steps first run the best-candidate
// walk down the cell chain, one cell per cycle, after a registered eligibility check.
// One item in flight; the next is accepted while a result waits in the output register.
// Reset clears all queue valid bits at once; no clearing pass.
module disk_request_scheduler_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // track, arrival_time
  input  logic [dsch_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  // func
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // served_track, seek_distance, time_now, total_seek, sweeping_up, pending_count
  output logic [dsch_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  // status
  output logic [dsch_pkg::STATUS_BITS-1:0]      m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dsch_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [dsch_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);
  import dsch_pkg::*;

  fsm_e                  fsm_q, fsm_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  scan_q;
  logic [TRACK_BITS-1:0] start_q;
  logic [ADV_BITS-1:0]   idle_adv_q, rev_adv_q;
  logic [TRACK_BITS-1:0] head_q, head_d;
  logic [TIME_BITS-1:0]  time_q, time_d;
  logic [TIME_BITS-1:0]  seek_q, seek_d;
  logic                  up_q, up_d;
  logic                  first_q, first_d;
  logic [CNT_BITS-1:0]   pend_q, pend_d;
  logic                  func_q;
  logic [TRACK_BITS-1:0] in_trk_q;
  logic [TIME_BITS-1:0]  in_arr_q;
  res_t                  res_q, res_d;
  res_t                  out_q;
  logic                  m_valid_q;
  logic                  in_acc, cfg_acc, need_search, commit, out_load;
  cell_ctl_t             ctl;
  view_t                 view;
  cand_t                 best;
  logic [TRACK_BITS-1:0] head0_trk;
  logic                  serve;
  logic [IDX_BITS-1:0]   serve_idx;
  logic [TRACK_BITS-1:0] serve_trk, serve_dist;
  status_e               status;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_load = (fsm_q == FSM_OUT) && (!m_valid_q || m_axis_tready);
  assign need_search = (s_axis_tuser == FUNC_STEP) && (pend_q != '0) && (scan_q || first_q);

  // next state
  always_comb begin
    fsm_d = fsm_q;
    cnt_d = cnt_q;
    unique case (fsm_q)
      FSM_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          fsm_d = need_search ? FSM_SEARCH : FSM_COMMIT;
        end
      end
      FSM_SEARCH: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(QUEUE_DEPTH)) begin
          fsm_d = FSM_COMMIT;
        end
      end
      FSM_COMMIT: fsm_d = FSM_OUT;
      FSM_OUT: begin
        if (out_load) begin
          fsm_d = FSM_IDLE;
        end
      end
      default: fsm_d = FSM_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (fsm_q == FSM_IDLE);
    cfg_ready_o   = 1'b1;
    commit        = (fsm_q == FSM_COMMIT);
  end

  // item outcome
  always_comb begin
    head_d     = head_q;
    time_d     = time_q;
    seek_d     = seek_q;
    up_d       = up_q;
    first_d    = first_q;
    pend_d     = pend_q;
    serve      = 1'b0;
    serve_idx  = '0;
    serve_trk  = '0;
    serve_dist = '0;
    ctl        = '0;
    ctl.trk    = in_trk_q;
    ctl.arr    = in_arr_q;
    status     = ST_EMPTY;
    priority if (func_q == FUNC_ADD && pend_q == CNT_BITS'(QUEUE_DEPTH)) begin
      status = ST_FULL;
    end else if (func_q == FUNC_ADD) begin
      status   = ST_ADDED;
      ctl.load = commit;
      ctl.sel  = IDX_BITS'(pend_q);
      pend_d   = pend_q + 1'b1;
    end else if (pend_q == '0) begin
      status = ST_EMPTY;
    end else if (!scan_q && !first_q) begin
      serve      = 1'b1;
      serve_idx  = '0;
      serve_trk  = head0_trk;
      serve_dist = abs_diff(head_q, head0_trk);
      first_d    = 1'b1;
    end else if (best.found) begin
      serve      = 1'b1;
      serve_idx  = best.idx;
      serve_trk  = best.trk;
      serve_dist = best.gap;
    end else begin
      status = ST_IDLE;
      if (scan_q) begin
        time_d = time_q + TIME_BITS'(rev_adv_q);
        up_d   = !up_q;
      end else begin
        time_d = time_q + TIME_BITS'(idle_adv_q);
      end
    end
    if (serve) begin
      status     = ST_SERVED;
      time_d     = time_q + TIME_BITS'(serve_dist);
      seek_d     = seek_q + TIME_BITS'(serve_dist);
      head_d     = serve_trk;
      pend_d     = pend_q - 1'b1;
      ctl.remove = commit;
      ctl.sel    = serve_idx;
    end
    res_d.status  = status;
    res_d.served  = serve_trk;
    res_d.seek    = serve_dist;
    res_d.now     = time_d;
    res_d.total   = seek_d;
    res_d.up      = up_d;
    res_d.pending = pend_d;
  end

  assign view.head = head_q;
  assign view.now  = time_q;
  assign view.scan = scan_q;
  assign view.up   = up_q;

  dsch_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .view_i      (view),
    .head0_trk_o (head0_trk),
    .best_o      (best)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q      <= FSM_IDLE;
      cnt_q      <= '0;
      scan_q     <= 1'b0;
      start_q    <= '0;
      idle_adv_q <= ADV_BITS'(30);
      rev_adv_q  <= ADV_BITS'(20);
      head_q     <= '0;
      time_q     <= '0;
      seek_q     <= '0;
      up_q       <= 1'b1;
      first_q    <= 1'b0;
      pend_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      cnt_q <= cnt_d;
      if (cfg_acc) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_SCAN_MODE:   scan_q <= cfg_data_i[0];
          CFG_START_TRACK: begin
            start_q <= TRACK_BITS'(cfg_data_i);
            head_q  <= TRACK_BITS'(cfg_data_i);
          end
          CFG_IDLE_ADV:    idle_adv_q <= ADV_BITS'(cfg_data_i);
          CFG_REV_ADV:     rev_adv_q  <= ADV_BITS'(cfg_data_i);
          default:         scan_q <= scan_q;
        endcase
      end else if (commit) begin
        head_q  <= head_d;
        time_q  <= time_d;
        seek_q  <= seek_d;
        up_q    <= up_d;
        first_q <= first_d;
        pend_q  <= pend_d;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q   <= s_axis_tuser;
      in_trk_q <= s_axis_tdata[TRACK_BITS-1:0];
      in_arr_q <= s_axis_tdata[TRACK_BITS +: TIME_BITS];
    end
    if (commit) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = OUT_DATA_BITS'({out_q.pending, out_q.up, out_q.total, out_q.now,
                                         out_q.seek, out_q.served});

  logic unused_start;
  assign unused_start = ^start_q;

endmodule

// ===== rtl/dsch_checker.sv =====
`include "disk_request_scheduler_top_assert.svh"

module dsch_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic [dsch_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  input logic                                  s_axis_tuser,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [dsch_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  input logic [dsch_pkg::STATUS_BITS-1:0]      m_axis_tuser,
  input logic                                  cfg_valid_i,
  input logic                                  cfg_ready_o,
  input logic [dsch_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input logic [dsch_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);
  import dsch_pkg::*;

  `DSCH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  `DSCH_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while one is in flight")

  `DSCH_ASSERT_NOW(a_no_seek_unless_served, m_axis_tvalid && m_axis_tuser != ST_SERVED, m_axis_tdata[2*TRACK_BITS-1:0] == '0, "track or seek set on a non-service result")

  `DSCH_ASSERT_NOW(a_pending_bound, m_axis_tvalid, m_axis_tdata[OUT_PEND_LSB +: CNT_BITS] <= CNT_BITS'(QUEUE_DEPTH), "pending count above queue depth")

  `DSCH_ASSERT_NOW(a_full_count, m_axis_tvalid && m_axis_tuser == ST_FULL, m_axis_tdata[OUT_PEND_LSB +: CNT_BITS] == CNT_BITS'(QUEUE_DEPTH), "full status with free entries")

  logic unused_ports;
  assign unused_ports = ^{s_axis_tdata, s_axis_tuser, cfg_valid_i, cfg_ready_o, cfg_index_i,
                          cfg_data_i};

endmodule

bind disk_request_scheduler_top dsch_checker u_dsch_checker (.*);
